// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/gdfs_pkg.sv =====
// Package with types, constants and commands of the grid path search.
package gdfs_pkg;
   localparam int GRID_MAX = 32;
   localparam int STACK_DEPTH = 1024;
   localparam int CW = $clog2(GRID_MAX);
   localparam int OW = 2 * CW;
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int DW = SW + 1;
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_SEARCH = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;
   localparam logic [0:0] CSR_GRID_SIZE = 1'b0;
   localparam logic [0:0] CSR_ATTEMPT_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] cell_x;
      logic [4:0] cell_y;
      logic cell_occupied;
      logic [4:0] target_x;
      logic [4:0] target_y;
      logic [9:0] path_index;
   } req_type;

   typedef struct packed {
      logic found;
      logic [10:0] path_length;
      logic [4:0] path_x;
      logic [4:0] path_y;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_WRITE, ST_READ_ADDR, ST_READ_DATA, ST_S_INIT, ST_S_ENTER,
      ST_S_ENTER_CHK, ST_S_TOP, ST_S_TOP_DATA, ST_S_STEP, ST_RESP
   } state_type;

   typedef struct packed {
      logic load_req;
      logic do_write;
      logic read_addr;
      logic read_capture;
      logic s_init;
      logic enter_read;
      logic enter_commit;
      logic top_read;
      logic step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic kind_write;
      logic kind_search;
      logic kind_read;
      logic enter_target;
      logic enter_done;
      logic stack_empty;
      logic want_enter;
      logic found;
   } sts_type;
endpackage

// ===== design/grid_dfs_path_search_top.sv =====
// From acceptance, a write or an unused kind passes the write and result states, and a
// path read also its address and data states; a search tries its start cell, then walks
// the grid one direction step at a time, tries each cell that a step attempts, and ends
// when the target is entered or the walk stack runs empty. One item at a time; the next
// item is taken at the edge that accepts the result. Reset is synchronous; all 1024 grid
// cells are then cleared before the first item, and registers return to 32 and 1000.
module grid_dfs_path_search_top import gdfs_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data,
   input  logic csr_write_enable,
   input  logic [0:0] csr_index,
   input  logic [11:0] csr_write_data
);
   cmd_type cmd;
   sts_type sts;
   logic rsp_full;

   gdfs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_full(rsp_full), .sts(sts), .cmd(cmd)
   );

   gdfs_datapath u_dp (
      .clock(clock), .reset(reset), .req_data(req_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .cmd(cmd), .sts(sts),
      .rsp_ready(rsp_ready), .rsp_valid(rsp_valid), .rsp_full(rsp_full),
      .rsp_data(rsp_data)
   );
endmodule

// ===== design/gdfs_ctrl.sv =====
// Controller state machine of the grid path search.
`include "assert_macros.svh"
module gdfs_ctrl import gdfs_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic rsp_full,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_full;
            if (req_valid && req_ready) begin
               cmd.load_req = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (sts.kind_write) begin
               cmd.do_write = 1'b1;
               state_in = ST_RESP;
            end else if (sts.kind_search) begin
               state_in = ST_S_INIT;
            end else if (sts.kind_read) begin
               state_in = ST_READ_ADDR;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_READ_ADDR: begin
            cmd.read_addr = 1'b1;
            state_in = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            cmd.read_capture = 1'b1;
            state_in = ST_RESP;
         end
         ST_S_INIT: begin
            cmd.s_init = 1'b1;
            state_in = ST_S_ENTER;
         end
         ST_S_ENTER: begin
            cmd.enter_read = 1'b1;
            state_in = ST_S_ENTER_CHK;
         end
         ST_S_ENTER_CHK: begin
            cmd.enter_commit = 1'b1;
            if (sts.enter_target) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_S_TOP;
            end
         end
         ST_S_TOP: begin
            if (sts.stack_empty) begin
               state_in = ST_RESP;
            end else begin
               cmd.top_read = 1'b1;
               state_in = ST_S_TOP_DATA;
            end
         end
         ST_S_TOP_DATA: begin
            state_in = ST_S_STEP;
         end
         ST_S_STEP: begin
            cmd.step = 1'b1;
            if (sts.want_enter) begin
               state_in = ST_S_ENTER;
            end else begin
               state_in = ST_S_TOP;
            end
         end
         ST_RESP: begin
            cmd.rsp_load = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_IMPL(a_ready_idle, clock, reset, !req_ready || state_ff == ST_IDLE)
   `ASSERT_NEXT(a_load_next, clock, reset, cmd.load_req, state_ff == ST_WRITE)
   `ASSERT_NEXT(a_resp_idle, clock, reset, cmd.rsp_load, state_ff == ST_IDLE)
endmodule

// ===== design/gdfs_datapath.sv =====
// Datapath of the grid path search: grid, walk stack and result register.
`include "assert_macros.svh"
module gdfs_datapath import gdfs_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  req_type req_data,
   input  logic csr_write_enable,
   input  logic [0:0] csr_index,
   input  logic [11:0] csr_write_data,
   input  cmd_type cmd,
   output sts_type sts,
   input  logic rsp_ready,
   output logic rsp_valid,
   output logic rsp_full,
   output rsp_type rsp_data
);
   localparam int STW = 2 * CW + 3;

   logic occ_mem [GRID_MAX*GRID_MAX];
   logic [STW-1:0] stk_mem [STACK_DEPTH];
   logic clr_active_ff, clr_active_in;
   logic [OW-1:0] clr_addr_ff;

   logic [5:0] grid_size_ff;
   logic [11:0] limit_ff;
   req_type req_ff;
   logic [DW-1:0] depth_ff;
   logic [11:0] count_ff;
   logic found_ff;
   logic [CW:0] nx_ff, ny_ff;
   logic occ_rd_ff;
   logic [STW-1:0] top_ff;
   logic [CW-1:0] px_ff, py_ff;
   logic full_ff;
   rsp_type rsp_ff;
   logic [CW:0] n_size;
   logic [11:0] count_inc;
   logic enter_ok;
   logic [OW-1:0] n_addr;
   logic [CW-1:0] tx, ty;
   logic [2:0] tdir;
   logic dir_ok;
   logic [CW:0] sx, sy;

   always_comb begin
      if (grid_size_ff == 6'd0) begin
         n_size = (CW+1)'(1);
      end else if ({1'b0, grid_size_ff} > 7'(GRID_MAX)) begin
         n_size = (CW+1)'(GRID_MAX);
      end else begin
         n_size = (CW+1)'(grid_size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= 6'd32;
         limit_ff <= 12'd1000;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_GRID_SIZE) begin
            grid_size_ff <= csr_write_data[5:0];
         end else begin
            limit_ff <= csr_write_data;
         end
      end
   end

   assign count_inc = (count_ff < 12'd4095) ? count_ff + 12'd1 : count_ff;
   assign n_addr = {nx_ff[CW-1:0], ny_ff[CW-1:0]};
   assign enter_ok = !(count_inc > limit_ff) && nx_ff < n_size && ny_ff < n_size
                     && !occ_rd_ff && depth_ff < DW'(STACK_DEPTH);
   assign tx = top_ff[STW-1 -: CW];
   assign ty = top_ff[STW-1-CW -: CW];
   assign tdir = top_ff[2:0];

   always_comb begin
      sx = {1'b0, tx};
      sy = {1'b0, ty};
      dir_ok = 1'b0;
      case (tdir)
         3'd0: begin dir_ok = ty != '0; sy = {1'b0, ty} - 1'b1; end
         3'd1: begin sy = {1'b0, ty} + 1'b1; dir_ok = sy < n_size; end
         3'd2: begin sx = {1'b0, tx} + 1'b1; dir_ok = sx < n_size; end
         3'd3: begin dir_ok = tx != '0; sx = {1'b0, tx} - 1'b1; end
         default: dir_ok = 1'b0;
      endcase
   end

   assign clr_active_in = clr_active_ff && clr_addr_ff != '1;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         if (clr_active_ff) clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         occ_mem[clr_addr_ff] <= 1'b0;
      end else if (cmd.do_write) begin
         occ_mem[{req_ff.cell_x, req_ff.cell_y}] <= req_ff.cell_occupied;
      end else if (cmd.enter_commit && (enter_ok || nx_ff < (CW+1)'(GRID_MAX)
                   && ny_ff < (CW+1)'(GRID_MAX) && !(depth_ff == '0 && count_ff == '0))) begin
         occ_mem[n_addr] <= 1'b1;
      end
      if (cmd.enter_read) occ_rd_ff <= occ_mem[n_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.enter_commit && enter_ok) begin
         stk_mem[depth_ff[SW-1:0]] <= {nx_ff[CW-1:0], ny_ff[CW-1:0], 3'd0};
      end else if (cmd.step && tdir < 3'd4) begin
         stk_mem[depth_ff[SW-1:0] - 1'b1] <= {tx, ty, tdir + 3'd1};
      end
      if (cmd.top_read) begin
         top_ff <= stk_mem[depth_ff[SW-1:0] - 1'b1];
      end else if (cmd.read_addr) begin
         top_ff <= stk_mem[SW'(depth_ff - DW'(1) - DW'(req_ff.path_index))];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         count_ff <= '0;
         found_ff <= 1'b0;
      end else if (cmd.s_init) begin
         depth_ff <= '0;
         count_ff <= '0;
         found_ff <= 1'b0;
      end else if (cmd.enter_commit) begin
         count_ff <= count_inc;
         if (enter_ok) begin
            depth_ff <= depth_ff + 1'b1;
            if (nx_ff[CW-1:0] == req_ff.target_x[CW-1:0] && nx_ff[CW] == 1'b0
                && ny_ff[CW-1:0] == req_ff.target_y[CW-1:0] && ny_ff[CW] == 1'b0) begin
               found_ff <= 1'b1;
            end
         end
      end else if (cmd.step && tdir >= 3'd4) begin
         depth_ff <= depth_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
      if (cmd.s_init) begin
         nx_ff <= (CW+1)'(req_ff.cell_x);
         ny_ff <= (CW+1)'(req_ff.cell_y);
      end else if (cmd.step) begin
         nx_ff <= sx;
         ny_ff <= sy;
      end
      if (cmd.load_req) begin
         px_ff <= '0;
         py_ff <= '0;
      end else if (cmd.read_capture && found_ff
                   && DW'(req_ff.path_index) < depth_ff) begin
         px_ff <= tx;
         py_ff <= ty;
      end
   end

   assign sts.kind_write = req_ff.kind == KIND_WRITE;
   assign sts.kind_search = req_ff.kind == KIND_SEARCH;
   assign sts.kind_read = req_ff.kind == KIND_READ;
   assign sts.enter_target = enter_ok && nx_ff == (CW+1)'(req_ff.target_x)
                             && ny_ff == (CW+1)'(req_ff.target_y);
   assign sts.enter_done = enter_ok;
   assign sts.stack_empty = depth_ff == '0;
   assign sts.want_enter = tdir < 3'd4 && dir_ok;
   assign sts.found = found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         full_ff <= 1'b1;
      end else if (rsp_ready) begin
         full_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_ff.found <= found_ff;
         rsp_ff.path_length <= found_ff ? 11'(depth_ff) : 11'd0;
         rsp_ff.path_x <= 5'(px_ff);
         rsp_ff.path_y <= 5'(py_ff);
      end
   end

   assign rsp_valid = full_ff;
   assign rsp_full = (full_ff && !rsp_ready) || clr_active_ff;
   assign rsp_data = rsp_ff;

   `ASSERT_IMPL(a_depth_max, clock, reset, depth_ff <= DW'(STACK_DEPTH))
   `ASSERT_NEXT(a_push, clock, reset, cmd.enter_commit && enter_ok,
                depth_ff == $past(depth_ff) + 1'b1)
   `ASSERT_IMPL(a_found_depth, clock, reset, !found_ff || depth_ff != '0)
endmodule

// ===== tb/sv/grid_dfs_path_search_top_tb.sv =====
// Self-checking testbench for the grid depth-first path search block.
`timescale 1ns / 1ps

module grid_dfs_path_search_top_tb import gdfs_pkg::*;;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [0:0] csr_index = CSR_GRID_SIZE;
   logic [11:0] csr_write_data = '0;

   grid_dfs_path_search_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #2 clock = ~clock;

   req_type pending_q[$];
   rsp_type expected_q[$];

   bit grid_occ[GRID_MAX * GRID_MAX];
   bit [4:0] walk_x[STACK_DEPTH];
   bit [4:0] walk_y[STACK_DEPTH];
   bit [2:0] walk_dir[STACK_DEPTH];
   int walk_depth;
   int attempts;
   bit path_found;
   int cfg_size = 32;
   int cfg_limit = 1000;

   int cycle_count = 0;
   int mismatches = 0;
   int results_seen = 0;
   int searches_done = 0;
   int searches_found = 0;
   int reads_done = 0;
   int items_queued = 0;
   bit calm;

   function automatic int active_size();
      if (cfg_size == 0) return 1;
      if (cfg_size > GRID_MAX) return GRID_MAX;
      return cfg_size;
   endfunction

   // Returns 0 on a failed attempt, 1 when the cell is entered, 2 at the goal.
   function automatic int try_enter(int x, int y, int tx, int ty, int n);
      if (attempts < 4095) attempts++;
      if (attempts > cfg_limit) return 0;
      if (x >= n || y >= n) return 0;
      if (grid_occ[x * GRID_MAX + y]) return 0;
      if (walk_depth >= STACK_DEPTH) return 0;
      grid_occ[x * GRID_MAX + y] = 1'b1;
      walk_x[walk_depth] = 5'(x);
      walk_y[walk_depth] = 5'(y);
      walk_dir[walk_depth] = 3'd0;
      walk_depth++;
      return (x == tx && y == ty) ? 2 : 1;
   endfunction

   function automatic void walk_grid(int sx, int sy, int tx, int ty);
      int n;
      int r;
      int x;
      int y;
      int d;
      int nx;
      int ny;
      bit ok;
      n = active_size();
      path_found = 1'b0;
      walk_depth = 0;
      attempts = 0;
      r = try_enter(sx, sy, tx, ty, n);
      if (r == 2) begin
         path_found = 1'b1;
         return;
      end
      while (walk_depth > 0) begin
         x = walk_x[walk_depth - 1];
         y = walk_y[walk_depth - 1];
         d = walk_dir[walk_depth - 1];
         if (d >= 4) begin
            walk_depth--;
            continue;
         end
         walk_dir[walk_depth - 1] = 3'(d + 1);
         nx = x;
         ny = y;
         case (d)
            0: begin
               ok = (y != 0);
               ny = y - 1;
            end
            1: begin
               ok = (y + 1 < n);
               ny = y + 1;
            end
            2: begin
               ok = (x + 1 < n);
               nx = x + 1;
            end
            default: begin
               ok = (x != 0);
               nx = x - 1;
            end
         endcase
         if (!ok) continue;
         r = try_enter(nx, ny, tx, ty, n);
         if (r == 2) begin
            path_found = 1'b1;
            return;
         end
         if (r == 0) grid_occ[nx * GRID_MAX + ny] = 1'b1;
      end
   endfunction

   function automatic rsp_type predict_result(req_type r);
      rsp_type p;
      p = '0;
      case (r.kind)
         KIND_WRITE: grid_occ[r.cell_x * GRID_MAX + r.cell_y] = r.cell_occupied;
         KIND_SEARCH: begin
            walk_grid(r.cell_x, r.cell_y, r.target_x, r.target_y);
            searches_done++;
            if (path_found) searches_found++;
         end
         KIND_READ: begin
            reads_done++;
            if (path_found && r.path_index < walk_depth) begin
               p.path_x = walk_x[walk_depth - 1 - r.path_index];
               p.path_y = walk_y[walk_depth - 1 - r.path_index];
            end
         end
         default: ;
      endcase
      p.found = path_found;
      p.path_length = path_found ? walk_depth[10:0] : 11'd0;
      return p;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end
   assign calm = (cycle_count % 5000) < 1200;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_q.insert(expected_q.size(), predict_result(req_data));
         if (!req_valid || req_ready) begin
            if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
               req_data <= pending_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               rsp_type want;
               want = expected_q.pop_front();
               if (rsp_data.found !== want.found || rsp_data.path_length !== want.path_length
                   || rsp_data.path_x !== want.path_x || rsp_data.path_y !== want.path_y) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", want, rsp_data);
               end
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= 25);
      end
   end

   task automatic add_item(logic [1:0] kind, int cx, int cy, int occ, int tx, int ty,
                           int idx);
      req_type r;
      r.kind = kind;
      r.cell_x = 5'((cx < 0) ? $urandom_range(31) : cx);
      r.cell_y = 5'((cy < 0) ? $urandom_range(31) : cy);
      r.cell_occupied = 1'((occ < 0) ? $urandom_range(1) : occ);
      r.target_x = 5'((tx < 0) ? $urandom_range(31) : tx);
      r.target_y = 5'((ty < 0) ? $urandom_range(31) : ty);
      r.path_index = 10'((idx < 0) ? $urandom_range(1023) : idx);
      pending_q.insert(pending_q.size(), r);
      items_queued++;
   endtask

   task automatic wait_drained();
      while (results_seen < items_queued) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_registers(int raw_size, int limit);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_GRID_SIZE;
      csr_write_data <= {6'($urandom_range(63)), 6'(raw_size)};
      @(posedge clock);
      csr_index <= CSR_ATTEMPT_LIMIT;
      csr_write_data <= 12'(limit);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_size = raw_size & 63;
      cfg_limit = limit & 4095;
   endtask

   function automatic int pick_coord(int span);
      if ($urandom_range(9) == 0) return $urandom_range(31);
      return $urandom_range(span - 1);
   endfunction

   task automatic run_phase(int raw_size, int limit, int block_pct, int searches);
      int n;
      int span;
      int sx;
      int sy;
      int tx;
      int ty;
      int reads;
      wait_drained();
      set_registers(raw_size, limit);
      n = active_size();
      span = (n > 10) ? 10 : n;
      for (int x = 0; x < span; x++)
         for (int y = 0; y < span; y++)
            add_item(KIND_WRITE, x, y, ($urandom_range(99) < block_pct), -1, -1, -1);
      repeat ($urandom_range(3)) add_item(KIND_WRITE, -1, -1, -1, -1, -1, -1);
      for (int s = 0; s < searches; s++) begin
         sx = pick_coord(span);
         sy = pick_coord(span);
         tx = pick_coord(span);
         ty = pick_coord(span);
         if ($urandom_range(9) != 0) begin
            add_item(KIND_WRITE, sx, sy, 0, -1, -1, -1);
            add_item(KIND_WRITE, tx, ty, 0, -1, -1, -1);
         end
         add_item(KIND_SEARCH, sx, sy, -1, tx, ty, -1);
         reads = span * span + 2;
         if (reads > 30) reads = 30;
         for (int i = 0; i < reads; i++) add_item(KIND_READ, -1, -1, -1, -1, -1, i);
         repeat (2) add_item(KIND_READ, -1, -1, -1, -1, -1, -1);
         if ($urandom_range(3) == 0) add_item(KIND_SPARE, -1, -1, -1, -1, -1, -1);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: two by two grid with path reads, then the special cases.
      set_registers(2, 1000);
      add_item(KIND_WRITE, 0, 1, 1, 0, 0, 0);
      add_item(KIND_WRITE, 31, 31, 1, 31, 31, 1023);
      add_item(KIND_SEARCH, 0, 0, 0, 1, 1, 0);
      for (int i = 0; i < 5; i++) add_item(KIND_READ, 0, 0, 0, 0, 0, i);
      add_item(KIND_READ, 31, 31, 1, 31, 31, 1023);
      add_item(KIND_SPARE, 31, 31, 1, 31, 31, 1023);
      add_item(KIND_WRITE, 0, 0, 0, 0, 0, 0);
      add_item(KIND_WRITE, 1, 0, 0, 0, 0, 0);
      add_item(KIND_SEARCH, 5, 0, 0, 0, 0, 0);
      add_item(KIND_SEARCH, 0, 0, 0, 7, 0, 0);
      add_item(KIND_WRITE, 0, 0, 0, 0, 0, 0);
      add_item(KIND_WRITE, 1, 0, 0, 0, 0, 0);
      add_item(KIND_SEARCH, 0, 0, 0, 0, 0, 0);
      add_item(KIND_READ, 0, 0, 0, 0, 0, 0);
      add_item(KIND_READ, 0, 0, 0, 0, 0, 1);
      wait_drained();
      set_registers(0, 1);
      add_item(KIND_WRITE, 0, 0, 0, 0, 0, 0);
      add_item(KIND_SEARCH, 0, 0, 0, 0, 0, 0);
      add_item(KIND_READ, 0, 0, 0, 0, 0, 0);

      run_phase(32, 4095, 10, 1);
      run_phase(40, 1, 20, 1);
      run_phase(63, 1000, 25, 1);
      run_phase(1, 4095, 0, 2);
      while (items_queued < 950) begin
         case ($urandom_range(7))
            0: run_phase(0, $urandom_range(1, 4095), 20, 1);
            1: run_phase($urandom_range(2, 8), $urandom_range(1, 40), 20, 1);
            2: run_phase($urandom_range(2, 8), 4095, $urandom_range(0, 40), 2);
            default: run_phase($urandom_range(2, 7), 1000, $urandom_range(10, 35), 1);
         endcase
      end

      wait_drained();
      repeat (50) @(posedge clock);
      $display("Covered %0d items: %0d searches (%0d reached the goal), %0d path reads.",
               items_queued, searches_done, searches_found, reads_done);
      $display("Checked %0d results with %0d mismatches.", results_seen, mismatches);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("grid_dfs_path_search_top test passed");
      end else begin
         $display("grid_dfs_path_search_top test failed");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("Timeout with %0d results outstanding.", expected_q.size());
      $display("grid_dfs_path_search_top test failed");
      $finish;
   end

endmodule
